// ----- sv/sle_pkg.sv -----
// Shared constants, command codes and types of the sorted list engine.
package sle_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned CountW  = $clog2(Depth + 1);
  localparam int unsigned DataW   = 32;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned StatusW = 2;

  // Command codes carried on the input tuser
  localparam logic [FuncW-1:0] FUNC_INSERT   = 3'd0;
  localparam logic [FuncW-1:0] FUNC_DEL_MIN  = 3'd1;
  localparam logic [FuncW-1:0] FUNC_DEL_MAX  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_DEL_VAL  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_DISPLAY  = 3'd4;

  // Status codes carried on the output tuser
  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NOTFOUND = 2'd2;
  localparam logic [StatusW-1:0] STATUS_FULL     = 2'd3;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DEL_VAL,
    OP_ROTATE
  } sle_op_e;

  typedef struct packed {
    sle_op_e                  op;
    logic signed [DataW-1:0]  value;
  } sle_cmd_t;

endpackage

// ----- sv/sle_cell.sv -----
// One storage cell of the sorted chain: holds an entry and its valid bit.
module sle_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sle_pkg::sle_cmd_t                cmd_i,
  input  logic signed [sle_pkg::DataW-1:0] left_val_i,
  input  logic                             left_valid_i,
  input  logic                             left_gt_i,
  input  logic signed [sle_pkg::DataW-1:0] right_val_i,
  input  logic                             right_valid_i,
  input  logic signed [sle_pkg::DataW-1:0] head_val_i,
  output logic signed [sle_pkg::DataW-1:0] val_o,
  output logic                             valid_o,
  output logic                             gt_o,
  output logic                             match_o
);
  import sle_pkg::*;

  logic signed [DataW-1:0] val_q, val_d;
  logic                    valid_q, valid_d;
  logic                    lt;

  // Compare the held entry against the broadcast value
  assign gt_o    = !valid_q || (val_q > cmd_i.value);
  assign match_o = valid_q && (val_q == cmd_i.value);
  assign lt      = valid_q && (val_q < cmd_i.value);

  // Pick the next entry from this cell, a neighbour or the command
  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    unique case (cmd_i.op)
      OP_INSERT: begin
        if (gt_o) begin
          val_d   = left_gt_i ? left_val_i : cmd_i.value;
          valid_d = valid_q || left_valid_i;
        end
      end
      OP_POP_FRONT: begin
        val_d   = right_val_i;
        valid_d = right_valid_i;
      end
      OP_POP_BACK: begin
        valid_d = valid_q && right_valid_i;
      end
      OP_DEL_VAL: begin
        if (!lt) begin
          val_d   = right_val_i;
          valid_d = right_valid_i;
        end
      end
      OP_ROTATE: begin
        if (valid_q) begin
          val_d = right_valid_i ? right_val_i : head_val_i;
        end
      end
      default: begin
        val_d   = val_q;
        valid_d = valid_q;
      end
    endcase
  end

  // Hold the entry; only the valid bit is cleared by reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule

// ----- sv/sle_chain.sv -----
// Row of sorted cells with the head, tail and match summaries.
module sle_chain (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sle_pkg::sle_cmd_t                cmd_i,
  output logic signed [sle_pkg::DataW-1:0] head_val_o,
  output logic signed [sle_pkg::DataW-1:0] tail_val_o,
  output logic                             found_o
);
  import sle_pkg::*;

  logic signed [DataW-1:0] val   [Depth];
  logic                    valid [Depth];
  logic                    gt    [Depth];
  logic [Depth-1:0]        match;
  logic [DataW-1:0]        tail_terms [Depth];

  // Build the chain, with fixed neighbours at both ends
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic signed [DataW-1:0] left_val, right_val;
    logic                    left_valid, left_gt, right_valid;

    if (g == 0) begin : g_first
      assign left_val   = '0;
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_mid_left
      assign left_val   = val[g-1];
      assign left_valid = valid[g-1];
      assign left_gt    = gt[g-1];
    end

    if (g == Depth - 1) begin : g_last
      assign right_val   = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_right
      assign right_val   = val[g+1];
      assign right_valid = valid[g+1];
    end

    sle_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd_i),
      .left_val_i    (left_val),
      .left_valid_i  (left_valid),
      .left_gt_i     (left_gt),
      .right_val_i   (right_val),
      .right_valid_i (right_valid),
      .head_val_i    (val[0]),
      .val_o         (val[g]),
      .valid_o       (valid[g]),
      .gt_o          (gt[g]),
      .match_o       (match[g])
    );

    // Mask in the entry of the last valid cell
    assign tail_terms[g] = (valid[g] && !right_valid) ? val[g] : '0;
  end

  // Merge the one-hot tail terms
  always_comb begin
    tail_val_o = '0;
    for (int i = 0; i < Depth; i++) begin
      tail_val_o = tail_val_o | tail_terms[i];
    end
  end

  assign head_val_o = val[0];
  assign found_o    = |match;

endmodule

// ----- sv/sorted_list_engine_top.sv -----
// Top level of the sorted list engine: command decode, display sequencer, result register.
//
//   channel   dir  tdata             tuser          tlast
//   s_axis    in   value [31:0]      func [2:0]     -
//   m_axis    out  value_out [31:0]  status [1:0]   last
//
// Insert and the three deletes, if they succeed, update every cell at the edge that takes
// the request, since every cell compares and shifts at once; the result shows in the next
// cycle and the next request may be taken at the following edge.
// Display takes the request, then streams one entry per cycle while the output is not
// stalled, by rotating the cell chain: a store of n entries gives its n results, the next
// request is taken only once the last of them is loaded, and the chain is back in place
// afterwards.
// Reset clears every valid bit and the count; the store is empty at once.
// A stalled result holds in the output register and blocks further requests.
module sorted_list_engine_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sle_pkg::DataW-1:0]     s_axis_tdata,  // value
  input  logic [sle_pkg::FuncW-1:0]     s_axis_tuser,  // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sle_pkg::DataW-1:0]     m_axis_tdata,  // value_out
  output logic [sle_pkg::StatusW-1:0]   m_axis_tuser,  // status
  output logic                          m_axis_tlast   // last
);
  import sle_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DISP = 1'b1;

  logic                    state_q, state_d;
  logic [CountW-1:0]       count_q, count_d;
  logic [CountW-1:0]       rem_q, rem_d;
  logic                    m_valid_q, m_valid_d;
  logic [DataW-1:0]        m_data_q, m_data_d;
  logic [StatusW-1:0]      m_status_q, m_status_d;
  logic                    m_last_q, m_last_d;
  logic                    out_free, accept, full, empty, out_load;
  sle_cmd_t                cmd;
  logic signed [DataW-1:0] head_val, tail_val;
  logic                    found;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CountW'(Depth));
  assign empty         = (count_q == '0);

  sle_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .head_val_o (head_val),
    .tail_val_o (tail_val),
    .found_o    (found)
  );

  // Decode the request or advance the display
  always_comb begin
    cmd.op     = OP_HOLD;
    cmd.value  = $signed(s_axis_tdata);
    state_d    = state_q;
    count_d    = count_q;
    rem_d      = rem_q;
    out_load   = 1'b0;
    m_data_d   = m_data_q;
    m_status_d = m_status_q;
    m_last_d   = m_last_q;
    if (state_q == ST_DISP) begin
      if (out_free) begin
        cmd.op     = OP_ROTATE;
        out_load   = 1'b1;
        m_data_d   = head_val;
        m_status_d = STATUS_OK;
        m_last_d   = (rem_q == CountW'(1));
        rem_d      = rem_q - CountW'(1);
        if (rem_q == CountW'(1)) begin
          state_d = ST_IDLE;
        end
      end
    end else if (accept) begin
      m_data_d = '0;
      m_last_d = 1'b1;
      unique case (s_axis_tuser)
        FUNC_INSERT: begin
          out_load = 1'b1;
          if (full) begin
            m_status_d = STATUS_FULL;
          end else begin
            cmd.op     = OP_INSERT;
            count_d    = count_q + CountW'(1);
            m_status_d = STATUS_OK;
          end
        end
        FUNC_DEL_MIN, FUNC_DEL_MAX: begin
          out_load = 1'b1;
          if (empty) begin
            m_status_d = STATUS_EMPTY;
          end else begin
            cmd.op     = (s_axis_tuser == FUNC_DEL_MIN) ? OP_POP_FRONT : OP_POP_BACK;
            count_d    = count_q - CountW'(1);
            m_status_d = STATUS_OK;
            m_data_d   = (s_axis_tuser == FUNC_DEL_MIN) ? head_val : tail_val;
          end
        end
        FUNC_DEL_VAL: begin
          out_load = 1'b1;
          if (empty) begin
            m_status_d = STATUS_EMPTY;
          end else if (found) begin
            cmd.op     = OP_DEL_VAL;
            count_d    = count_q - CountW'(1);
            m_status_d = STATUS_OK;
            m_data_d   = s_axis_tdata;
          end else begin
            m_status_d = STATUS_NOTFOUND;
          end
        end
        FUNC_DISPLAY: begin
          if (empty) begin
            out_load   = 1'b1;
            m_status_d = STATUS_EMPTY;
          end else begin
            state_d = ST_DISP;
            rem_d   = count_q;
          end
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end
  end

  // Hold a result until taken, drop it once taken
  assign m_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rem_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rem_q     <= rem_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q   <= m_data_d;
    m_status_q <= m_status_d;
    m_last_q   <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

endmodule
